/* design/mi3_pkg.sv */
package mi3_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  localparam int DW   = DATA_WIDTH;
  localparam int PW   = 2 * DW;
  localparam int CW   = 2 * DW + 1;
  localparam int LB   = CW - DW;
  localparam int LPW  = DW + LB + 1;
  localparam int DETW = DW + CW + 2;
  localparam int NSH  = 2 * FRAC_BITS + 1;
  localparam int NW   = ((CW + NSH > DETW) ? CW + NSH : DETW) + 1;
  localparam int DVW  = DETW + 1;
  localparam int QW   = DW + 2;
  localparam int RW   = DVW + QW;
  localparam int NS   = QW;
  localparam int NE   = 9;

  localparam int MQ_DEPTH = 4;
  localparam int MQ_AW    = $clog2(MQ_DEPTH);

  typedef struct packed {
    logic signed [DW-1:0] in_r0c0;
    logic signed [DW-1:0] in_r0c1;
    logic signed [DW-1:0] in_r0c2;
    logic signed [DW-1:0] in_r1c0;
    logic signed [DW-1:0] in_r1c1;
    logic signed [DW-1:0] in_r1c2;
    logic signed [DW-1:0] in_r2c0;
    logic signed [DW-1:0] in_r2c1;
    logic signed [DW-1:0] in_r2c2;
  } in_t;

  typedef struct packed {
    logic signed [DW-1:0] out_r0c0;
    logic signed [DW-1:0] out_r0c1;
    logic signed [DW-1:0] out_r0c2;
    logic signed [DW-1:0] out_r1c0;
    logic signed [DW-1:0] out_r1c1;
    logic signed [DW-1:0] out_r1c2;
    logic signed [DW-1:0] out_r2c0;
    logic signed [DW-1:0] out_r2c1;
    logic signed [DW-1:0] out_r2c2;
    logic                 singular;
  } out_t;

  typedef struct packed {
    logic          neg;
    logic [NW-1:0] num;
  } lane_t;

  typedef struct packed {
    logic               singular;
    logic [DVW-1:0]     den;
    lane_t [NE-1:0]     lane;
  } mid_t;

endpackage

/* design/mi3_front.sv */
module mi3_front
  import mi3_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_vld,
  input  in_t  in_item,
  output logic out_vld,
  output mid_t out_item
);

  localparam int XA [NE] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int XB [NE] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int XC [NE] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int XD [NE] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};
  localparam int AI [3]  = '{0, 3, 6};

  logic signed [DW-1:0]   m [NE];
  logic [6:1]             v_r;
  logic signed [PW-1:0]   pa1_r [NE];
  logic signed [PW-1:0]   pb1_r [NE];
  logic signed [DW-1:0]   m1_r  [3];
  logic signed [CW-1:0]   adj2_r [NE];
  logic signed [DW-1:0]   m2_r  [3];
  logic signed [CW-1:0]   adj3_r [NE];
  logic signed [LPW-1:0]  plo3_r [3];
  logic signed [PW-1:0]   phi3_r [3];
  logic signed [CW-1:0]   adj4_r [NE];
  logic signed [DETW-1:0] pr4_r [3];
  logic signed [CW-1:0]   adj5_r [NE];
  logic signed [DETW-1:0] det5_r;
  mid_t                   item6_r;
  logic [DETW-1:0]        dmag;

  assign m[0] = in_item.in_r0c0;
  assign m[1] = in_item.in_r0c1;
  assign m[2] = in_item.in_r0c2;
  assign m[3] = in_item.in_r1c0;
  assign m[4] = in_item.in_r1c1;
  assign m[5] = in_item.in_r1c2;
  assign m[6] = in_item.in_r2c0;
  assign m[7] = in_item.in_r2c1;
  assign m[8] = in_item.in_r2c2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[5:1], in_vld};
    end
  end

  // products, cofactors, determinant partials
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NE; k++) begin
        pa1_r[k]  <= PW'(m[XA[k]]) * PW'(m[XB[k]]);
        pb1_r[k]  <= PW'(m[XC[k]]) * PW'(m[XD[k]]);
        adj2_r[k] <= CW'(pa1_r[k]) - CW'(pb1_r[k]);
        adj3_r[k] <= adj2_r[k];
        adj4_r[k] <= adj3_r[k];
        adj5_r[k] <= adj4_r[k];
      end
      for (int t = 0; t < 3; t++) begin
        m1_r[t]   <= m[t];
        m2_r[t]   <= m1_r[t];
        plo3_r[t] <= LPW'(m2_r[t]) * LPW'($signed({1'b0, adj2_r[AI[t]][LB-1:0]}));
        phi3_r[t] <= PW'(m2_r[t]) * PW'($signed(adj2_r[AI[t]][CW-1:LB]));
        pr4_r[t]  <= (DETW'(phi3_r[t]) <<< LB) + DETW'(plo3_r[t]);
      end
      det5_r <= pr4_r[0] + pr4_r[1] + pr4_r[2];
    end
  end

  assign dmag = det5_r[DETW-1] ? DETW'(-det5_r) : DETW'(det5_r);

  always_ff @(posedge clk) begin
    if (en) begin
      item6_r.singular <= (det5_r == '0);
      item6_r.den      <= {dmag, 1'b0};
      for (int l = 0; l < NE; l++) begin
        item6_r.lane[l].neg <= adj5_r[l][CW-1] ^ det5_r[DETW-1];
        item6_r.lane[l].num <= (NW'(adj5_r[l][CW-1] ? CW'(-adj5_r[l]) : CW'(adj5_r[l]))
                                << NSH) + NW'(dmag);
      end
    end
  end

  assign out_vld  = v_r[6];
  assign out_item = item6_r;

endmodule

/* design/mi3_queue.sv */
module mi3_queue
  import mi3_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr,
  input  mid_t wr_data,
  input  logic rd,
  output mid_t rd_data,
  output logic full,
  output logic empty
);

  mid_t              mem [MQ_DEPTH];
  logic [MQ_AW-1:0]  wp_r;
  logic [MQ_AW-1:0]  rp_r;
  logic [MQ_AW:0]    cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (MQ_AW+1)'(wr) - (MQ_AW+1)'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wp_r] <= wr_data;
  end

  assign rd_data = mem[rp_r];
  assign full    = (cnt_r == (MQ_AW+1)'(MQ_DEPTH));
  assign empty   = (cnt_r == '0);

endmodule

/* design/mi3_back.sv */
module mi3_back
  import mi3_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic mid_vld,
  input  mid_t mid_item,
  output logic mid_pop,
  input  logic pop,
  output logic out_vld,
  output out_t out_item
);

  localparam logic [DW:0] HALF = (DW+1)'(1) << (DW - 1);

  logic                 en;
  logic [NS:0]          v_r;
  logic                 ov_r;
  out_t                 out_r;
  logic [RW-1:0]        rem_r [NS+1][NE];
  logic [QW-1:0]        q_r   [NS+1][NE];
  logic                 neg_r [NS+1][NE];
  logic [DVW-1:0]       den_r [NS+1];
  logic                 sg_r  [NS+1];
  logic [DW-1:0]        res   [NE];
  out_t                 res_item;

  function automatic logic [DW-1:0] sat_q(input logic [QW-1:0] q, input logic neg);
    logic [DW:0] mag;
    logic [DW:0] negm;
    mag = q[DW:0];
    if (neg) begin
      if (q[QW-1] || mag > HALF) mag = HALF;
      negm = -mag;
      return negm[DW-1:0];
    end
    if (q[QW-1] || mag > HALF - 1'b1) mag = HALF - 1'b1;
    return mag[DW-1:0];
  endfunction

  assign en      = !ov_r || pop;
  assign mid_pop = en && mid_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= '0;
      ov_r <= 1'b0;
    end else if (en) begin
      v_r  <= {v_r[NS-1:0], mid_vld};
      ov_r <= v_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0] <= mid_item.den;
      sg_r[0]  <= mid_item.singular;
      for (int l = 0; l < NE; l++) begin
        rem_r[0][l] <= RW'(mid_item.lane[l].num);
        q_r[0][l]   <= '0;
        neg_r[0][l] <= mid_item.lane[l].neg;
      end
    end
  end

  // one quotient bit per stage, top bit flags overflow
  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int SH = QW - 1 - s;
    for (genvar l = 0; l < NE; l++) begin : g_lane
      logic [RW-1:0] trial;
      assign trial = rem_r[s][l] - (RW'(den_r[s]) << SH);
      always_ff @(posedge clk) begin
        if (en) begin
          if (!trial[RW-1]) begin
            rem_r[s+1][l] <= trial;
            q_r[s+1][l]   <= q_r[s][l] | (QW'(1) << SH);
          end else begin
            rem_r[s+1][l] <= rem_r[s][l];
            q_r[s+1][l]   <= q_r[s][l];
          end
          neg_r[s+1][l] <= neg_r[s][l];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        den_r[s+1] <= den_r[s];
        sg_r[s+1]  <= sg_r[s];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < NE; l++) begin
      res[l] = sg_r[NS] ? '0 : sat_q(q_r[NS][l], neg_r[NS][l]);
    end
    res_item.out_r0c0 = res[0];
    res_item.out_r0c1 = res[1];
    res_item.out_r0c2 = res[2];
    res_item.out_r1c0 = res[3];
    res_item.out_r1c1 = res[4];
    res_item.out_r1c2 = res[5];
    res_item.out_r2c0 = res[6];
    res_item.out_r2c1 = res[7];
    res_item.out_r2c2 = res[8];
    res_item.singular = sg_r[NS];
  end

  always_ff @(posedge clk) begin
    if (en) out_r <= res_item;
  end

  assign out_vld  = ov_r;
  assign out_item = out_r;

endmodule

/* design/matrix_inverse_3x3_unit.sv */
// Push to result passes 6 cofactor and determinant stages, 1 in the queue
// and 36 in the divider pipeline. Throughput: one matrix per cycle while
// pop drains the output; set by the bit-per-stage divider lanes.
// Reset (synchronous, rst_n low) empties the pipelines and the queue;
// no clearing pass.
module matrix_inverse_3x3_unit
  import mi3_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  output logic full,
  input  in_t  in_data,
  output logic empty,
  input  logic pop,
  output out_t out_data
);

  logic front_en;
  logic f_vld;
  mid_t f_item;
  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;
  mid_t q_item;
  logic b_vld;

  assign front_en = !(f_vld && q_full);
  assign full     = !front_en;
  assign q_push   = f_vld && !q_full;

  mi3_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (front_en),
    .in_vld   (push && front_en),
    .in_item  (in_data),
    .out_vld  (f_vld),
    .out_item (f_item)
  );

  mi3_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_push),
    .wr_data (f_item),
    .rd      (q_pop),
    .rd_data (q_item),
    .full    (q_full),
    .empty   (q_empty)
  );

  mi3_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .mid_vld  (!q_empty),
    .mid_item (q_item),
    .mid_pop  (q_pop),
    .pop      (pop),
    .out_vld  (b_vld),
    .out_item (out_data)
  );

  assign empty = !b_vld;

  a_full_src: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> (f_vld && q_full))
    else $error("full without a blocked queue");

  a_pop_src: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue read while empty");

  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.singular) |->
      (out_data.out_r0c0 == '0 && out_data.out_r1c1 == '0 && out_data.out_r2c2 == '0))
    else $error("singular result with nonzero entries");

endmodule
